// ===== design/vlss_pkg.sv =====
// shared constants for the video line sync sequencer
package vlss_pkg;

  localparam int CNT_W   = 8;
  localparam int PHASE_W = 3;
  localparam int SRC_W   = 2;
  localparam int DRIVE_W = 3;
  localparam int TASK_W  = 2;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  // frame phases
  localparam logic [PHASE_W-1:0] PH_SINGLE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ALL    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BOTTOM = 3'd2;
  localparam logic [PHASE_W-1:0] PH_VSYNC  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TOP    = 3'd4;

  // pattern sources
  localparam logic [SRC_W-1:0] SRC_LOWER = 2'd0;
  localparam logic [SRC_W-1:0] SRC_UPPER = 2'd1;
  localparam logic [SRC_W-1:0] SRC_HSYNC = 2'd2;

  // task window codes
  localparam logic [TASK_W-1:0] TASK_NONE  = 2'd0;
  localparam logic [TASK_W-1:0] TASK_SHORT = 2'd1;
  localparam logic [TASK_W-1:0] TASK_LONG  = 2'd2;

  localparam logic [DRIVE_W-1:0] DRIVE_OFF = 3'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_END = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_END = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VSYNC_CNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_CNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_EN   = 3'd5;

  // bank select mask on the line counter
  localparam logic [2:0] LOW3_MASK = 3'h7;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TASK_W-1:0]  task_trig;
    logic [DRIVE_W-1:0] drive;
    logic               reload;
    logic [SRC_W-1:0]   src;
  } result_t;

endpackage

// ===== design/video_line_sync_sequencer_core.sv =====
// video line sync sequencer: per-line phase, bank and pin drive sequencing
// an accepted line-end transfer's result is registered and shows on out_tdata in the next cycle
// throughput: one input transfer per cycle while the output register is free or draining,
//   set by the single compare/update step on the phase and line counter registers
// an input transfer with line_end low is taken and produces no result
// rst_n is synchronous, active low: phase all lines, counter zero, registers at defaults
module video_line_sync_sequencer_core
  import vlss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] line_end, rest zero
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [1:0] pattern_source, [2] pattern_reload,
                                            // [5:3] video_drive, [7:6] task_trigger,
                                            // [10:8] frame_phase, rest zero
);

  // configuration registers
  logic [CNT_W-1:0] active_end_r;
  logic [CNT_W-1:0] bottom_end_r;
  logic [CNT_W-1:0] vsync_cnt_r;
  logic [CNT_W-1:0] top_cnt_r;
  logic [CNT_W-1:0] single_sel_r;
  logic             video_en_r;

  // sequencer state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // result register
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;

  logic             in_xfer;
  logic             step;
  logic [2:0]       low3;
  logic [DRIVE_W-1:0] drive_code;
  logic [SRC_W-1:0] bank_src;
  logic [CNT_W-1:0] cnt_inc;

  // the output register is the only buffer: take new input whenever it is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign step      = in_xfer && in_tdata[0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(result_t)){1'b0}}, res_r};

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_end_r <= CNT_W'(240);
      bottom_end_r <= CNT_W'(250);
      vsync_cnt_r  <= CNT_W'(3);
      top_cnt_r    <= CNT_W'(9);
      single_sel_r <= '0;
      video_en_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_END: active_end_r <= cfg_wdata;
        REG_BOTTOM_END: bottom_end_r <= cfg_wdata;
        REG_VSYNC_CNT:  vsync_cnt_r  <= cfg_wdata;
        REG_TOP_CNT:    top_cnt_r    <= cfg_wdata;
        REG_SINGLE_SEL: single_sel_r <= cfg_wdata;
        REG_VIDEO_EN:   video_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // bank and pin line come from the counter before the increment
  assign low3       = cnt_r[2:0] & LOW3_MASK;
  assign drive_code = DRIVE_W'(3'd4 - {1'b0, low3[1:0]});
  assign bank_src   = (low3 inside {3'd3, 3'd4, 3'd5, 3'd6}) ? SRC_UPPER : SRC_LOWER;
  assign cnt_inc    = cnt_r + CNT_W'(1);

  // phase machine, evaluated on the incremented counter
  always_comb begin
    phase_nxt         = phase_r;
    cnt_nxt           = cnt_inc;
    res_nxt.src       = bank_src;
    res_nxt.reload    = 1'b0;
    res_nxt.drive     = DRIVE_OFF;
    res_nxt.task_trig = TASK_NONE;
    case (phase_r)
      PH_SINGLE, PH_ALL: begin
        if (cnt_inc >= active_end_r) begin
          // counter keeps running into bottom blank
          phase_nxt         = PH_BOTTOM;
          res_nxt.reload    = 1'b1;
          res_nxt.src       = SRC_LOWER;
          res_nxt.task_trig = TASK_SHORT;
        end else if (phase_r == PH_SINGLE) begin
          res_nxt.drive = (cnt_inc == single_sel_r) ? drive_code : DRIVE_OFF;
        end else begin
          res_nxt.drive = video_en_r ? drive_code : DRIVE_OFF;
        end
      end
      PH_BOTTOM: begin
        if (cnt_inc >= bottom_end_r) begin
          cnt_nxt        = '0;
          phase_nxt      = PH_VSYNC;
          res_nxt.reload = 1'b1;
          res_nxt.src    = SRC_HSYNC;
        end
      end
      PH_VSYNC: begin
        if (cnt_inc >= vsync_cnt_r) begin
          cnt_nxt           = '0;
          phase_nxt         = PH_TOP;
          res_nxt.reload    = 1'b1;
          res_nxt.src       = SRC_LOWER;
          res_nxt.task_trig = TASK_LONG;
        end
      end
      PH_TOP: begin
        if (cnt_inc >= top_cnt_r) begin
          cnt_nxt        = '0;
          phase_nxt      = (single_sel_r != '0) ? PH_SINGLE : PH_ALL;
          res_nxt.reload = 1'b1;
          res_nxt.src    = SRC_LOWER;
        end
      end
      default: begin
        // unreachable phase codes recover to all-lines video
        cnt_nxt        = '0;
        phase_nxt      = PH_ALL;
        res_nxt.reload = 1'b1;
        res_nxt.src    = SRC_LOWER;
        res_nxt.drive  = drive_code;
      end
    endcase
    res_nxt.phase = phase_nxt;
  end

  // state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ALL;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (in_tready) begin
        out_valid_r <= step;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the video line sync sequencer core
module tb;
  import vlss_pkg::*;

  localparam int HOLD_LEN   = 40;       // long receiver hold-off, in cycles
  localparam int SETTLE_CYC = 4;        // quiet cycles after the last result
  localparam int MAX_SHOWN  = 10;       // mismatches printed in full

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACTIVE_END;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;     // [0] line_end, rest zero
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [1:0] pattern_source, [2] pattern_reload,
                                            // [5:3] video_drive, [7:6] task_trigger,
                                            // [10:8] frame_phase, rest zero

  video_line_sync_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // register mirror, starts at the reset defaults
  logic [7:0]         end_active  = 8'd240;
  logic [7:0]         end_bottom  = 8'd250;
  logic [7:0]         vsync_lines = 8'd3;
  logic [7:0]         top_lines   = 8'd9;
  logic [7:0]         shown_line  = 8'd0;
  logic               video_on    = 1'b1;

  // sequencer state mirror
  logic [PHASE_W-1:0] frame_ph = PH_ALL;
  logic [CNT_W-1:0]   line_cnt = '0;
  logic [DRIVE_W-1:0] pin_line = 3'd1;

  // expected per-line results, oldest first
  result_t pending_lines[$];

  // idling knobs, percent of cycles
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // long hold-off requests, served by the receiver process
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;

  // run statistics
  int unsigned bad_fields      = 0;
  int unsigned results_checked = 0;
  int unsigned lines_sent      = 0;
  int unsigned idle_sent       = 0;
  int unsigned frames_seen     = 0;
  int unsigned counter_wraps   = 0;
  int unsigned reg_loads       = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout with %0d results still pending", pending_lines.size());
    $display("CHECK FAILED");
    $finish;
  end

  // one step of the sequencer for a finished scan line
  function automatic result_t predict_line();
    result_t    r;
    logic [2:0] low3;
    // bank and pin line come from the counter before it advances
    low3     = line_cnt[2:0] & LOW3_MASK;
    pin_line = 3'd4 - {1'b0, low3[1:0]};
    r.src       = (low3 >= 3'd3 && low3 <= 3'd6) ? SRC_UPPER : SRC_LOWER;
    r.reload    = 1'b0;
    r.drive     = DRIVE_OFF;
    r.task_trig = TASK_NONE;
    if (line_cnt == '1) counter_wraps++;
    line_cnt = line_cnt + CNT_W'(1);
    case (frame_ph)
      PH_SINGLE, PH_ALL: begin
        // counter keeps running into bottom blank, no clear here
        if (line_cnt >= end_active) begin
          frame_ph    = PH_BOTTOM;
          r.reload    = 1'b1;
          r.src       = SRC_LOWER;
          r.task_trig = TASK_SHORT;
        end else if (frame_ph == PH_SINGLE) begin
          r.drive = (line_cnt == shown_line) ? pin_line : DRIVE_OFF;
        end else begin
          r.drive = video_on ? pin_line : DRIVE_OFF;
        end
      end
      PH_BOTTOM: begin
        if (line_cnt >= end_bottom) begin
          line_cnt = '0;
          frame_ph = PH_VSYNC;
          r.reload = 1'b1;
          r.src    = SRC_HSYNC;
          frames_seen++;
        end
      end
      PH_VSYNC: begin
        if (line_cnt >= vsync_lines) begin
          line_cnt    = '0;
          frame_ph    = PH_TOP;
          r.reload    = 1'b1;
          r.src       = SRC_LOWER;
          r.task_trig = TASK_LONG;
        end
      end
      PH_TOP: begin
        if (line_cnt >= top_lines) begin
          line_cnt = '0;
          frame_ph = (shown_line != 8'd0) ? PH_SINGLE : PH_ALL;
          r.reload = 1'b1;
          r.src    = SRC_LOWER;
        end
      end
      default: begin
        // unused phase codes fall back to all lines
        line_cnt = '0;
        frame_ph = PH_ALL;
        r.reload = 1'b1;
        r.src    = SRC_LOWER;
        r.drive  = pin_line;
      end
    endcase
    r.phase = frame_ph;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      bad_fields++;
      if (bad_fields <= MAX_SHOWN)
        $display("mismatch in result %0d, %s: expected %0d, got %0d",
                 results_checked, name, want, got);
    end
  endfunction

  // result checker: every accepted output transfer against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[$bits(result_t)-1:0];
      if (pending_lines.size() == 0) begin
        bad_fields++;
        if (bad_fields <= MAX_SHOWN)
          $display("unexpected result 0x%h with nothing pending", out_tdata);
      end else begin
        want = pending_lines.pop_front();
        check_field("pattern_source", want.src, seen.src);
        check_field("pattern_reload", want.reload, seen.reload);
        check_field("video_drive", want.drive, seen.drive);
        check_field("task_trigger", want.task_trig, seen.task_trig);
        check_field("frame_phase", want.phase, seen.phase);
        check_field("padding", 0, out_tdata[OUT_DATA_W-1:$bits(result_t)]);
        results_checked++;
      end
    end
  end

  // receiver: random stalls, plus long hold-offs counted here
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_served < holds_asked) begin
        holds_served++;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one input transfer; valid stays high on return so back-to-back lines need no toggle
  task automatic send_line(input logic ends_line);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-1){1'b0}}, ends_line};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    lines_sent++;
    if (ends_line) pending_lines.push_back(predict_line());
    else idle_sent++;
  endtask

  // drop valid, wait for every pending result, then let the block settle
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_END: end_active  = val;
      REG_BOTTOM_END: end_bottom  = val;
      REG_VSYNC_CNT:  vsync_lines = val;
      REG_TOP_CNT:    top_lines   = val;
      REG_SINGLE_SEL: shown_line  = val;
      REG_VIDEO_EN:   video_on    = val[0];
      default: ;
    endcase
  endtask

  // full register set, only called with the block idle
  task automatic load_config(input logic [7:0] act_end, input logic [7:0] bot_end,
                             input logic [7:0] vs_cnt, input logic [7:0] top_cnt,
                             input logic [7:0] sel, input logic ven);
    write_reg(REG_ACTIVE_END, act_end);
    write_reg(REG_BOTTOM_END, bot_end);
    write_reg(REG_VSYNC_CNT, vs_cnt);
    write_reg(REG_TOP_CNT, top_cnt);
    write_reg(REG_SINGLE_SEL, sel);
    write_reg(REG_VIDEO_EN, {{(CFG_W-1){1'b0}}, ven});
    cfg_we <= 1'b0;
    reg_loads++;
  endtask

  // mostly short counts so frames cycle often, sometimes the extremes
  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 8'd0;
    if (r < 14) return 8'd255;
    return 8'($urandom_range(12, 1));
  endfunction

  // reset defaults: all-lines video, bank and pin line walk with the counter
  task automatic test_reset_defaults();
    repeat (4) send_line(1'b1);
    drain_and_settle();
  endtask

  // all counts at the top, then all at zero so every line changes phase
  task automatic test_phase_extremes();
    load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_line(1'b1);
    send_line(1'b0);
    send_line(1'b1);
    send_line(1'b1);
    drain_and_settle();
    load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_line(1'b1);
    send_line(1'b0);
    repeat (6) send_line(1'b1);
    drain_and_settle();
  endtask

  // short frame that comes back from top blank into single-line mode
  task automatic test_single_line();
    load_config(8'd4, 8'd6, 8'd1, 8'd1, 8'd2, 1'b1);
    repeat (16) send_line(1'b1);
    drain_and_settle();
  endtask

  // receiver holds off long enough that the core backs up into in_tready
  task automatic test_backpressure();
    load_config(8'd5, 8'd7, 8'd2, 8'd2, 8'd0, 1'b1);
    holds_asked++;
    repeat (20) send_line(1'b1);
    drain_and_settle();
    repeat (6) send_line(1'b1);
    drain_and_settle();
  endtask

  // long active video so the counter wraps past 255 inside bottom blank
  task automatic test_counter_wrap();
    int unsigned start_wraps;
    int unsigned guard;
    load_config(8'd255, 8'd3, 8'd1, 8'd1, 8'd0, 1'b1);
    gap_pct     = 12;
    stall_pct   = 12;
    start_wraps = counter_wraps;
    guard       = 0;
    while (counter_wraps == start_wraps && guard < 600) begin
      send_line(1'b1);
      guard++;
    end
    repeat (6) send_line(1'b1);
    drain_and_settle();
  endtask

  // random registers and line stream under each idling pattern
  task automatic test_random_mix();
    int unsigned gaps[4]   = '{0, 71, 0, 12};
    int unsigned stalls[4] = '{0, 0, 71, 12};
    logic [7:0]  sel;
    for (int m = 0; m < 4; m++) begin
      gap_pct   = gaps[m];
      stall_pct = stalls[m];
      repeat (2) begin
        sel = ($urandom_range(1) == 0) ? 8'd0 : pick_count();
        load_config(pick_count(), pick_count(), pick_count(), pick_count(), sel,
                    1'($urandom_range(1)));
        repeat (40) send_line($urandom_range(99) < 85);
        drain_and_settle();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_phase_extremes();
    test_single_line();
    test_backpressure();
    test_counter_wrap();
    test_random_mix();
    drain_and_settle();

    $display("sent %0d line transfers (%0d idle), checked %0d results",
             lines_sent, idle_sent, results_checked);
    $display("%0d frames into vsync, %0d counter wraps, %0d register set loads",
             frames_seen, counter_wraps, reg_loads);
    if (bad_fields == 0 && pending_lines.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
